// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int unsigned DATA_BITS = 8;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // register byte addresses
  localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
  localparam logic [2:0] REG_ACK_POLL    = 3'd4;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [7:0]  ACK_POLL_RST    = 8'd10;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_A     = 5'd1,
    PH_ST_B     = 5'd2,
    PH_SP_0     = 5'd3,
    PH_SP_A     = 5'd4,
    PH_SP_B     = 5'd5,
    PH_WB_LOW   = 5'd6,
    PH_WB_HIGH  = 5'd7,
    PH_ACK_LOW  = 5'd8,
    PH_ACK_POLL = 5'd9,
    PH_RB_LOW   = 5'd10,
    PH_RB_HIGH  = 5'd11,
    PH_AT_LOW   = 5'd12,
    PH_AT_HIGH  = 5'd13
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } i2cm_out_t;

endpackage

// ===== design/i2c_master_byte_engine.sv =====
// I2C master byte engine, one bus tick per accepted beat.
// Input channel (in_valid/in_ready/in_data): each beat is one tick of the bus
// timer and carries an optional command (start, stop, write byte, read byte)
// plus the sampled SDA level. Commands that arrive while busy are dropped.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// input beat, holding the SCL/SDA drive levels, busy, a done pulse, the last
// received byte and the missing-ack flag after that tick.
// The result of a tick is registered in the output register, or in the skid register while the output is held.
// Throughput: one tick per cycle while the receiver keeps up; the bus state
// and the result are computed in one pass from the state registers.
// Stall: a two-deep output (output register plus skid register) absorbs one
// extra tick; in_ready drops only while the skid register is full.
// Config (cfg_ APB port, always ready): 0x0 half_period_ticks (16 bit),
// 0x4 ack_poll_limit (8 bit). A zero in either acts as one. Write only while
// idle.
// Reset (rst_n, synchronous): bus released (SCL high, SDA undriven), phase
// idle, registers back to 100 and 10, output channel empty.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  i2cm_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output i2cm_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] half_r;
  logic [7:0]  lim_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic        nack_flag_r, nack_flag_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        nack_latch_r, nack_latch_nxt;
  logic        done;

  i2cm_out_t   res;
  i2cm_out_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        in_fire, out_fire, cfg_wr;
  logic [15:0] h_eff, tick_inc;
  logic [7:0]  lim_eff, poll_inc, shift_rb;
  logic [3:0]  bit_inc;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RST;
      lim_r  <= ACK_POLL_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ACK_POLL[2]) lim_r <= cfg_pwdata[7:0];
      else half_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_HALF_PERIOD[2]) cfg_prdata = {16'd0, half_r};
    else cfg_prdata = {24'd0, lim_r};
  end

  // ---------------- tick logic ----------------
  assign h_eff    = (half_r == 16'd0) ? 16'd1 : half_r;
  assign lim_eff  = (lim_r == 8'd0) ? 8'd1 : lim_r;
  assign tick_inc = tick_r + 16'd1;
  assign bit_inc  = bit_r + 4'd1;
  assign poll_inc = poll_r + 8'd1;
  assign shift_rb = {shift_r[6:0], in_data.sda_in};

  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    drv_nxt        = drv_r;
    nack_flag_nxt  = nack_flag_r;
    rx_nxt         = rx_r;
    nack_latch_nxt = nack_latch_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (in_data.command)
        CMD_START: begin
          {scl_nxt, sda_nxt, drv_nxt} = 3'b111;
          phase_nxt = PH_ST_A;
          tick_nxt  = 16'd0;
        end
        CMD_STOP: begin
          {scl_nxt, sda_nxt, drv_nxt} = 3'b001;
          phase_nxt = PH_SP_0;
          tick_nxt  = 16'd0;
        end
        CMD_WRITE: begin
          shift_nxt     = in_data.tx_byte;
          bit_nxt       = 4'd0;
          nack_flag_nxt = 1'b0;
          {scl_nxt, sda_nxt, drv_nxt} = {1'b0, in_data.tx_byte[7], 1'b1};
          phase_nxt = PH_WB_LOW;
          tick_nxt  = 16'd0;
        end
        CMD_READ: begin
          shift_nxt      = 8'd0;
          bit_nxt        = 4'd0;
          nack_latch_nxt = in_data.send_nack;
          {scl_nxt, sda_nxt, drv_nxt} = 3'b010;
          phase_nxt = PH_RB_LOW;
          tick_nxt  = 16'd0;
        end
        default: ;
      endcase
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= h_eff) begin
        tick_nxt = 16'd0;
        case (phase_r)
          PH_ST_A: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b101;
            phase_nxt = PH_ST_B;
          end
          PH_ST_B: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b001;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_SP_0: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b101;
            phase_nxt = PH_SP_A;
          end
          PH_SP_A: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b111;
            phase_nxt = PH_SP_B;
          end
          PH_SP_B: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b111;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_WB_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WB_HIGH;
          end
          PH_WB_HIGH: begin
            bit_nxt   = bit_inc;
            shift_nxt = {shift_r[6:0], 1'b0};
            if (bit_inc >= 4'(DATA_BITS)) begin
              {scl_nxt, sda_nxt, drv_nxt} = 3'b010;
              phase_nxt = PH_ACK_LOW;
            end else begin
              {scl_nxt, sda_nxt, drv_nxt} = {1'b0, shift_r[6], 1'b1};
              phase_nxt = PH_WB_LOW;
            end
          end
          PH_ACK_LOW: begin
            scl_nxt   = 1'b1;
            poll_nxt  = 8'd0;
            phase_nxt = PH_ACK_POLL;
          end
          PH_ACK_POLL: begin
            if (!in_data.sda_in) begin
              {scl_nxt, sda_nxt, drv_nxt} = 3'b011;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              poll_nxt = poll_inc;
              // timed out: flag it and close the transfer with a stop
              if (poll_inc >= lim_eff) begin
                nack_flag_nxt = 1'b1;
                {scl_nxt, sda_nxt, drv_nxt} = 3'b001;
                phase_nxt = PH_SP_0;
              end
            end
          end
          PH_RB_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_RB_HIGH;
          end
          PH_RB_HIGH: begin
            shift_nxt = shift_rb;
            bit_nxt   = bit_inc;
            if (bit_inc >= 4'(DATA_BITS)) begin
              rx_nxt = shift_rb;
              {scl_nxt, sda_nxt, drv_nxt} = {1'b0, nack_latch_r, 1'b1};
              phase_nxt = PH_AT_LOW;
            end else begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_RB_LOW;
            end
          end
          PH_AT_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_AT_HIGH;
          end
          PH_AT_HIGH: begin
            {scl_nxt, sda_nxt, drv_nxt} = 3'b011;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.sda_drive   = drv_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_nxt;
    res.ack_missing = nack_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= 16'd0;
      bit_r        <= 4'd0;
      shift_r      <= 8'd0;
      poll_r       <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      drv_r        <= 1'b0;
      nack_flag_r  <= 1'b0;
      rx_r         <= 8'd0;
      nack_latch_r <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      poll_r       <= poll_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      drv_r        <= drv_nxt;
      nack_flag_r  <= nack_flag_nxt;
      rx_r         <= rx_nxt;
      nack_latch_r <= nack_latch_nxt;
    end
  end

  // ---------------- result beats: output register plus skid ----------------
  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      out_valid_r  <= skid_valid_r | in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int NEVER_ACK = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  i2cm_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  i2cm_out_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_master_byte_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // engine state as predicted from the accepted ticks
  phase_t      bus_phase = PH_IDLE;
  logic [15:0] tick_cnt = '0;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [7:0]  poll_cnt = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        drv_q = 1'b0;
  logic        no_ack_q = 1'b0;
  logic        nack_sel = 1'b0;
  logic [7:0]  rx_hold = '0;
  logic [15:0] half_period = HALF_PERIOD_RST;
  logic [7:0]  poll_limit = ACK_POLL_RST;

  i2cm_out_t   pending_bus_states[$];
  int          errors = 0;
  int          ticks_sent = 0;
  int          beats_checked = 0;
  int          completions = 0;
  int          starts = 0, stops = 0, writes = 0, reads = 0, timeouts = 0;

  bit          idle_on = 1'b1;
  logic        stall_on = 1'b1;
  int          busy_noise_pct = 0;
  int          ready_wait = 0;

  function automatic i2cm_out_t advance_engine(i2cm_in_t it);
    logic [15:0] h;
    logic [7:0]  lim;
    logic        fin;
    i2cm_out_t   r;
    h = (half_period == 16'd0) ? 16'd1 : half_period;
    lim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
    fin = 1'b0;
    if (bus_phase == PH_IDLE) begin
      case (it.command)
        CMD_START: begin
          {scl_q, sda_q, drv_q} = 3'b111;
          bus_phase = PH_ST_A;
          tick_cnt = '0;
          starts++;
        end
        CMD_STOP: begin
          {scl_q, sda_q, drv_q} = 3'b001;
          bus_phase = PH_SP_0;
          tick_cnt = '0;
          stops++;
        end
        CMD_WRITE: begin
          shreg = it.tx_byte;
          bit_cnt = '0;
          no_ack_q = 1'b0;
          {scl_q, sda_q, drv_q} = {1'b0, shreg[7], 1'b1};
          bus_phase = PH_WB_LOW;
          tick_cnt = '0;
          writes++;
        end
        CMD_READ: begin
          shreg = '0;
          bit_cnt = '0;
          nack_sel = it.send_nack;
          {scl_q, sda_q, drv_q} = 3'b010;
          bus_phase = PH_RB_LOW;
          tick_cnt = '0;
          reads++;
        end
        default: ;
      endcase
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= h) begin
        tick_cnt = '0;
        case (bus_phase)
          PH_ST_A: begin
            {scl_q, sda_q, drv_q} = 3'b101;
            bus_phase = PH_ST_B;
          end
          PH_ST_B: begin
            {scl_q, sda_q, drv_q} = 3'b001;
            bus_phase = PH_IDLE;
            fin = 1'b1;
          end
          PH_SP_0: begin
            {scl_q, sda_q, drv_q} = 3'b101;
            bus_phase = PH_SP_A;
          end
          PH_SP_A: begin
            {scl_q, sda_q, drv_q} = 3'b111;
            bus_phase = PH_SP_B;
          end
          PH_SP_B: begin
            {scl_q, sda_q, drv_q} = 3'b111;
            bus_phase = PH_IDLE;
            fin = 1'b1;
          end
          PH_WB_LOW: begin
            scl_q = 1'b1;
            bus_phase = PH_WB_HIGH;
          end
          PH_WB_HIGH: begin
            bit_cnt = bit_cnt + 4'd1;
            shreg = {shreg[6:0], 1'b0};
            if (bit_cnt >= DATA_BITS) begin
              {scl_q, sda_q, drv_q} = 3'b010;
              bus_phase = PH_ACK_LOW;
            end else begin
              {scl_q, sda_q, drv_q} = {1'b0, shreg[7], 1'b1};
              bus_phase = PH_WB_LOW;
            end
          end
          PH_ACK_LOW: begin
            scl_q = 1'b1;
            poll_cnt = '0;
            bus_phase = PH_ACK_POLL;
          end
          PH_ACK_POLL: begin
            if (it.sda_in == 1'b0) begin
              {scl_q, sda_q, drv_q} = 3'b011;
              bus_phase = PH_IDLE;
              fin = 1'b1;
            end else begin
              poll_cnt = poll_cnt + 8'd1;
              // no ack within the poll budget: flag it and close with a stop
              if (poll_cnt >= lim) begin
                no_ack_q = 1'b1;
                {scl_q, sda_q, drv_q} = 3'b001;
                bus_phase = PH_SP_0;
                timeouts++;
              end
            end
          end
          PH_RB_LOW: begin
            scl_q = 1'b1;
            bus_phase = PH_RB_HIGH;
          end
          PH_RB_HIGH: begin
            shreg = {shreg[6:0], it.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= DATA_BITS) begin
              rx_hold = shreg;
              {scl_q, sda_q, drv_q} = {1'b0, nack_sel, 1'b1};
              bus_phase = PH_AT_LOW;
            end else begin
              scl_q = 1'b0;
              bus_phase = PH_RB_LOW;
            end
          end
          PH_AT_LOW: begin
            scl_q = 1'b1;
            bus_phase = PH_AT_HIGH;
          end
          PH_AT_HIGH: begin
            {scl_q, sda_q, drv_q} = 3'b011;
            bus_phase = PH_IDLE;
            fin = 1'b1;
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drv_q;
    r.busy_res = (bus_phase != PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rx_hold;
    r.ack_missing = no_ack_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // result side: compare each beat with the oldest prediction
  always @(posedge clk) begin : check_results
    i2cm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bus_states.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, got %0h",
                 $time, out_data);
        errors++;
      end else begin
        want = pending_bus_states.pop_front();
        check_field("scl_level", want.scl_level, out_data.scl_level);
        check_field("sda_level", want.sda_level, out_data.sda_level);
        check_field("sda_drive", want.sda_drive, out_data.sda_drive);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("ack_missing", want.ack_missing, out_data.ack_missing);
        beats_checked++;
        if (want.done_res) completions++;
      end
    end
  end

  // receiver backpressure: a fresh random stall after every beat while stall_on is set
  always @(posedge clk) begin : rx_stall
    int stall_len;
    if (!rst_n) begin
      out_ready <= 1'b1;
      ready_wait <= 0;
    end else if (out_ready) begin
      if (out_valid && stall_on) begin
        stall_len = $urandom_range(0, 7);
        if (stall_len != 0) begin
          ready_wait <= stall_len - 1;
          out_ready <= 1'b0;
        end
      end
    end else begin
      if (ready_wait == 0) out_ready <= 1'b1;
      else ready_wait <= ready_wait - 1;
    end
  end

  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx,
                           input logic nack, input logic sda);
    int gap;
    i2cm_in_t it;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.command = cmd;
    it.tx_byte = tx;
    it.send_nack = nack;
    it.sda_in = sda;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_bus_states.push_back(advance_engine(it));
    ticks_sent++;
  endtask

  // slave side of the bus: ack once enough polls have gone by, release SDA before that, random data in other phases
  function automatic logic slave_sda(input int ack_after);
    if (bus_phase == PH_ACK_POLL) return (poll_cnt >= ack_after) ? 1'b0 : 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // issue one command beat, then tick until the engine is idle again
  task automatic bus_cmd(input logic [2:0] cmd, input logic [7:0] tx,
                         input logic nack, input int ack_after);
    logic [2:0] c;
    send_tick(cmd, tx, nack, slave_sda(ack_after));
    while (bus_phase != PH_IDLE) begin
      c = ($urandom_range(0, 99) < busy_noise_pct) ? 3'($urandom_range(0, 7)) : CMD_NONE;
      send_tick(c, 8'($urandom), 1'($urandom), slave_sda(ack_after));
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bus_states.size() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_reg(input logic [2:0] addr);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    if (addr == REG_HALF_PERIOD) check_field("half_period_ticks readback", half_period, rd[15:0]);
    else check_field("ack_poll_limit readback", {8'd0, poll_limit}, {8'd0, rd[7:0]});
  endtask

  // upper bits carry junk on purpose; only the register width is kept
  task automatic set_reg(input logic [2:0] addr, input logic [15:0] value);
    logic [31:0] wdata;
    logic [31:0] rd;
    wdata = $urandom;
    if (addr == REG_HALF_PERIOD) begin
      wdata[15:0] = value;
      half_period = value;
    end else begin
      wdata[7:0] = value[7:0];
      poll_limit = value[7:0];
    end
    apb_access(1'b1, addr, wdata, rd);
    verify_reg(addr);
  endtask

  task automatic test_reset_defaults;
    verify_reg(REG_HALF_PERIOD);
    verify_reg(REG_ACK_POLL);
    bus_cmd(CMD_NONE, 8'h00, 1'b0, NEVER_ACK);
    bus_cmd(CMD_START, 8'h00, 1'b0, NEVER_ACK);
    drain();
  endtask

  task automatic test_directed;
    // zero in either register behaves as one
    set_reg(REG_HALF_PERIOD, 16'd0);
    set_reg(REG_ACK_POLL, 16'd0);
    bus_cmd(3'd5, 8'hFF, 1'b1, NEVER_ACK);
    bus_cmd(3'd6, 8'h00, 1'b0, NEVER_ACK);
    bus_cmd(3'd7, 8'hAA, 1'b1, NEVER_ACK);
    bus_cmd(CMD_START, 8'h00, 1'b0, NEVER_ACK);
    bus_cmd(CMD_WRITE, 8'h00, 1'b0, 0);
    bus_cmd(CMD_WRITE, 8'hFF, 1'b1, NEVER_ACK);
    bus_cmd(CMD_WRITE, 8'hA5, 1'b0, 0);
    bus_cmd(CMD_READ, 8'h00, 1'b0, NEVER_ACK);
    bus_cmd(CMD_READ, 8'hFF, 1'b1, NEVER_ACK);
    bus_cmd(CMD_STOP, 8'h00, 1'b0, NEVER_ACK);
    busy_noise_pct = 60;
    bus_cmd(CMD_START, 8'h3C, 1'b1, NEVER_ACK);
    bus_cmd(CMD_WRITE, 8'h96, 1'b0, NEVER_ACK);
    bus_cmd(CMD_READ, 8'h00, 1'b1, NEVER_ACK);
    busy_noise_pct = 0;
    drain();
    // full poll budget runs out
    set_reg(REG_HALF_PERIOD, 16'd1);
    set_reg(REG_ACK_POLL, 16'd255);
    bus_cmd(CMD_WRITE, 8'h3C, 1'b0, NEVER_ACK);
    bus_cmd(CMD_READ, 8'h00, 1'b0, NEVER_ACK);
    drain();
    set_reg(REG_ACK_POLL, 16'd1);
    bus_cmd(CMD_WRITE, 8'h81, 1'b0, NEVER_ACK);
    drain();
  endtask

  task automatic test_random_traffic;
    int stop_at;
    int seg;
    int n;
    int pick;
    int lim_eff;
    int ack_after;
    logic [2:0] cmd;
    stop_at = ticks_sent + 300;
    seg = 0;
    while (ticks_sent < stop_at) begin
      drain();
      case ($urandom_range(0, 5))
        0: set_reg(REG_HALF_PERIOD, 16'd0);
        1, 2: set_reg(REG_HALF_PERIOD, 16'd1);
        3: set_reg(REG_HALF_PERIOD, 16'd2);
        4: set_reg(REG_HALF_PERIOD, 16'd3);
        default: set_reg(REG_HALF_PERIOD, 16'($urandom_range(4, 6)));
      endcase
      set_reg(REG_ACK_POLL, 16'($urandom_range(0, 6)));
      lim_eff = (poll_limit == 8'd0) ? 1 : poll_limit;
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
      busy_noise_pct = $urandom_range(0, 1) ? 25 : 0;
      for (n = 0; n < 8; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) cmd = CMD_START;
        else if (pick < 48) cmd = CMD_WRITE;
        else if (pick < 73) cmd = CMD_READ;
        else if (pick < 88) cmd = CMD_STOP;
        else cmd = 3'($urandom_range(0, 1) ? $urandom_range(5, 7) : 0);
        ack_after = ($urandom_range(0, 3) == 0) ? NEVER_ACK : $urandom_range(0, lim_eff - 1);
        bus_cmd(cmd, 8'($urandom), 1'($urandom), ack_after);
        // hold off once until the receiver has caught up completely
        if (seg == 0 && n == 3) drain();
      end
      seg++;
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d bus ticks: %0d starts, %0d stops, %0d writes (%0d ack timeouts),",
             ticks_sent, starts, stops, writes, timeouts);
    $display("%0d reads; %0d result beats compared, %0d command completions seen.",
             reads, beats_checked, completions);
    if (errors == 0) begin
      $display("i2c_master_byte_engine verification clean");
    end else begin
      $display("i2c_master_byte_engine verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("i2c_master_byte_engine verification failed");
    $finish;
  end

endmodule
